// File: design/vqct_pkg.sv
// shared types, constants and helper functions of the voxel quad collision tagger
`default_nettype none
package vqct_pkg;

	localparam int MAX_QUADS = 255;
	localparam int MAX_SLOTS = 3;
	localparam int IDX_W     = 8;
	localparam int POS_W     = 20;
	localparam int LO_W      = POS_W + 1;
	localparam int OPA_W     = POS_W + 2;
	localparam int OPB_W     = 18;
	localparam int ACC_W     = 41;
	localparam int AXIS_W    = 16;
	localparam int SQ_W      = 31;
	localparam int SPAN_W    = 10;
	localparam logic [SPAN_W-1:0] VOXEL_ONE = SPAN_W'(256);

	// command codes of an input transaction
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_QUAD_COUNT = 2'd0;
	localparam logic [1:0] CFG_BOX_EXPAND = 2'd1;
	localparam logic [1:0] CFG_MAX_DIST   = 2'd2;
	localparam logic [1:0] CFG_UNUSED     = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CROSS,
		ST_DOT,
		ST_SPAN,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		AX_T,
		AX_B,
		AX_N
	} axis_t;

	typedef struct packed {
		logic signed [POS_W-1:0] cx;
		logic signed [POS_W-1:0] cy;
		logic signed [POS_W-1:0] cz;
		logic [23:0]             nrm;
		logic [23:0]             tan;
		logic [15:0]             tlen;
		logic [15:0]             blen;
	} quad_entry_t;

	typedef struct packed {
		logic                    clr;
		logic                    sub;
		logic signed [OPA_W-1:0] a;
		logic signed [OPB_W-1:0] b;
	} mac_op_t;

	// snorm8 byte with -128 clamped to -127
	function automatic logic signed [7:0] snorm(input logic [7:0] b);
		snorm = (b == 8'h80) ? 8'sh81 : signed'(b);
	endfunction

	// snorm component times 127
	function automatic logic signed [AXIS_W-1:0] scale127(input logic signed [7:0] s);
		logic signed [AXIS_W-1:0] x;
		x = AXIS_W'(s);
		scale127 = (x <<< 7) - x;
	endfunction

	// unsigned value times 16129 (16384 - 256 + 1)
	function automatic logic [SQ_W-1:0] axis_sq(input logic [15:0] v);
		logic [SQ_W-1:0] x;
		x = SQ_W'(v);
		axis_sq = (x << 14) - (x << 8) + x;
	endfunction

endpackage
`default_nettype wire

// File: design/vqct_if.sv
// channel interfaces for query/load transactions and result transactions
`default_nettype none
interface vqct_req_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [7:0]         quad_index;
	logic signed [19:0] pos_x;
	logic signed [19:0] pos_y;
	logic signed [19:0] pos_z;
	logic [23:0]        normal_packed;
	logic [23:0]        tangent_packed;
	logic [15:0]        tangent_half_len;
	logic [15:0]        bitangent_half_len;
	logic [7:0]         corner_solid_bits;

	modport source(output valid, cmd, quad_index, pos_x, pos_y, pos_z, normal_packed,
		tangent_packed, tangent_half_len, bitangent_half_len, corner_solid_bits,
		input ready);
	modport sink(input valid, cmd, quad_index, pos_x, pos_y, pos_z, normal_packed,
		tangent_packed, tangent_half_len, bitangent_half_len, corner_solid_bits,
		output ready);
endinterface

interface vqct_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] voxel_word;
	logic [7:0]  hit_count;
	logic        too_many_hits;

	modport source(output valid, voxel_word, hit_count, too_many_hits, input ready);
	modport sink(input valid, voxel_word, hit_count, too_many_hits, output ready);
endinterface
`default_nettype wire

// File: design/vqct_quad_mem.sv
// quad table memory, one write port and one registered read port
`default_nettype none
module vqct_quad_mem (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [vqct_pkg::IDX_W-1:0] waddr,
	input  wire vqct_pkg::quad_entry_t      wdata,
	input  wire logic                       re,
	input  wire logic [vqct_pkg::IDX_W-1:0] raddr,
	output vqct_pkg::quad_entry_t           rdata_q
);
	import vqct_pkg::*;

	quad_entry_t mem_q [MAX_QUADS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: design/vqct_mac.sv
// shared multiply-accumulate unit
`default_nettype none
module vqct_mac (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire vqct_pkg::mac_op_t                 op,
	output logic signed [vqct_pkg::ACC_W-1:0]      acc_q,
	output logic signed [vqct_pkg::ACC_W-1:0]      acc_d
);
	import vqct_pkg::*;

	logic signed [OPA_W+OPB_W-1:0] prod;
	logic signed [ACC_W-1:0]       base;

	// product and accumulate
	always_comb begin
		prod  = op.a * op.b;
		base  = op.clr ? '0 : acc_q;
		acc_d = op.sub ? base - ACC_W'(prod) : base + ACC_W'(prod);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= acc_d;
		end
	end
endmodule
`default_nettype wire

// File: design/voxel_quad_collision_tagger.sv
// voxel quad collision tagger top level: quad table, sequencer and shared mac
//
// A load transaction writes one quad into the table unless quad_index is 255.
// A query walks quads 0 to quad_count-1 through one shared multiply-accumulate
// unit: each quad takes one table read, the bitangent cross product, and a
// dot, span and compare per axis, with the later axes skipped when the tangent
// or bitangent test rejects the quad early. Input ready is low while a query
// runs. The result sits in an output register, so the next transaction may be
// taken while a result still waits. The user must write configuration only
// while idle; the block itself does not enforce it.
`default_nettype none
module voxel_quad_collision_tagger (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_wdata,
	vqct_req_if.sink        req,
	vqct_rsp_if.source      rsp
);
	import vqct_pkg::*;

	state_t state_q, state_d;
	axis_t  ax_q;
	logic [2:0]       cnt_q;
	logic [IDX_W-1:0] idx_q, count_q;
	logic [7:0]       quad_count_q, box_expand_q, max_dist_q;
	logic             out_valid_q;

	logic signed [LO_W-1:0]   lo_q [3];
	logic [SPAN_W-1:0]        w_q;
	logic signed [AXIS_W-1:0] b_q [3];
	logic signed [ACC_W-1:0]  d_q;
	logic [31:0]              word_q;
	logic [7:0]               hits_q;
	logic [31:0]              out_word_q;
	logic [7:0]               out_hits_q;
	logic                     out_many_q;

	logic        accept, mem_we, mem_re, mac_en;
	mac_op_t     mac_op;
	quad_entry_t wr_entry, ent;
	logic signed [ACC_W-1:0] acc_q, acc_d;

	logic signed [7:0]        sn [3];
	logic signed [7:0]        st [3];
	logic signed [POS_W-1:0]  cen [3];
	logic signed [AXIS_W-1:0] av [3];
	logic [17:0]              abs_sum;
	logic [1:0]               k;
	logic signed [OPA_W-1:0]  sel, diff;
	logic signed [ACC_W-1:0]  len, thr, far, near, plane_dist;
	logic axis_fail, quad_hit, quad_done, last_quad, out_free;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign wr_entry = '{cx: req.pos_x, cy: req.pos_y, cz: req.pos_z,
		nrm: req.normal_packed, tan: req.tangent_packed,
		tlen: req.tangent_half_len, blen: req.bitangent_half_len};

	vqct_quad_mem u_mem (
		.clk(clk), .we(mem_we), .waddr(req.quad_index), .wdata(wr_entry),
		.re(mem_re), .raddr(idx_q), .rdata_q(ent)
	);

	vqct_mac u_mac (
		.clk(clk), .en(mac_en), .op(mac_op), .acc_q(acc_q), .acc_d(acc_d)
	);

	// unpack axes of the current quad and pick the active axis
	always_comb begin
		cen[0] = ent.cx;
		cen[1] = ent.cy;
		cen[2] = ent.cz;
		for (int i = 0; i < 3; i++) begin
			sn[i] = snorm(ent.nrm[8*i +: 8]);
			st[i] = snorm(ent.tan[8*i +: 8]);
			case (ax_q)
				AX_T:    av[i] = scale127(st[i]);
				AX_B:    av[i] = b_q[i];
				default: av[i] = scale127(sn[i]);
			endcase
		end
		abs_sum = 18'(av[0][AXIS_W-1] ? -av[0] : av[0])
			+ 18'(av[1][AXIS_W-1] ? -av[1] : av[1])
			+ 18'(av[2][AXIS_W-1] ? -av[2] : av[2]);
		k    = cnt_q[1:0];
		sel  = av[k][AXIS_W-1] ? OPA_W'(lo_q[k]) + OPA_W'(w_q) : OPA_W'(lo_q[k]);
		diff = OPA_W'(cen[k]) - sel;
	end

	// axis compares: d_q is centre minus box minimum, acc_q the box span
	always_comb begin
		len  = ACC_W'(axis_sq((ax_q == AX_T) ? ent.tlen : ent.blen));
		thr  = ACC_W'(axis_sq({8'd0, max_dist_q}));
		far  = d_q - acc_q;
		near = -d_q;
		plane_dist = '0;
		if (far > plane_dist) plane_dist = far;
		if (near > plane_dist) plane_dist = near;
		axis_fail = (far > len) || (d_q < -len);
		quad_hit  = plane_dist < thr;
		quad_done = (ax_q == AX_N) || axis_fail;
		last_quad = idx_q == count_q - 8'd1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.cmd == CMD_QUERY) begin
					state_d = (quad_count_q == 8'd0) ? ST_DONE : ST_READ;
				end
			end
			ST_READ:  state_d = ST_CROSS;
			ST_CROSS: if (cnt_q == 3'd5) state_d = ST_DOT;
			ST_DOT:   if (cnt_q == 3'd2) state_d = ST_SPAN;
			ST_SPAN:  state_d = ST_CHECK;
			ST_CHECK: begin
				if (quad_done) state_d = last_quad ? ST_DONE : ST_READ;
				else state_d = ST_DOT;
			end
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs and mac operands
	always_comb begin
		req.ready = state_q == ST_IDLE;
		mem_we    = accept && req.cmd == CMD_LOAD && req.quad_index != IDX_W'(MAX_QUADS);
		mem_re    = state_q == ST_READ;
		mac_en    = 1'b0;
		mac_op    = '{clr: 1'b0, sub: 1'b0, a: '0, b: '0};
		unique case (state_q)
			ST_CROSS: begin
				mac_en     = 1'b1;
				mac_op.clr = !cnt_q[0];
				mac_op.sub = cnt_q[0];
				case (cnt_q)
					3'd0:    begin mac_op.a = OPA_W'(sn[1]); mac_op.b = OPB_W'(st[2]); end
					3'd1:    begin mac_op.a = OPA_W'(sn[2]); mac_op.b = OPB_W'(st[1]); end
					3'd2:    begin mac_op.a = OPA_W'(sn[2]); mac_op.b = OPB_W'(st[0]); end
					3'd3:    begin mac_op.a = OPA_W'(sn[0]); mac_op.b = OPB_W'(st[2]); end
					3'd4:    begin mac_op.a = OPA_W'(sn[0]); mac_op.b = OPB_W'(st[1]); end
					default: begin mac_op.a = OPA_W'(sn[1]); mac_op.b = OPB_W'(st[0]); end
				endcase
			end
			ST_DOT: begin
				mac_en     = 1'b1;
				mac_op.clr = cnt_q == 3'd0;
				mac_op.a   = diff;
				mac_op.b   = OPB_W'(av[k]);
			end
			ST_SPAN: begin
				mac_en     = 1'b1;
				mac_op.clr = 1'b1;
				mac_op.a   = OPA_W'(w_q);
				mac_op.b   = signed'(abs_sum);
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			ax_q         <= AX_T;
			idx_q        <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			quad_count_q <= 8'd0;
			box_expand_q <= 8'd51;
			max_dist_q   <= 8'd51;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_QUAD_COUNT: quad_count_q <= cfg_wdata;
					CFG_BOX_EXPAND: box_expand_q <= cfg_wdata;
					CFG_MAX_DIST:   max_dist_q   <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept && req.cmd == CMD_QUERY) begin
				idx_q   <= '0;
				count_q <= quad_count_q;
			end
			case (state_q)
				ST_READ: begin
					cnt_q <= '0;
					ax_q  <= AX_T;
				end
				ST_CROSS: cnt_q <= (cnt_q == 3'd5) ? 3'd0 : cnt_q + 3'd1;
				ST_DOT:   cnt_q <= (cnt_q == 3'd2) ? 3'd0 : cnt_q + 3'd1;
				ST_CHECK: begin
					if (quad_done) begin
						if (!last_quad) idx_q <= idx_q + 8'd1;
					end else begin
						ax_q <= (ax_q == AX_T) ? AX_B : AX_N;
					end
				end
				default: ;
			endcase
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && req.cmd == CMD_QUERY) begin
			lo_q[0] <= LO_W'(req.pos_x) - LO_W'(box_expand_q);
			lo_q[1] <= LO_W'(req.pos_y) - LO_W'(box_expand_q);
			lo_q[2] <= LO_W'(req.pos_z) - LO_W'(box_expand_q);
			w_q     <= VOXEL_ONE + {box_expand_q, 1'b0};
			word_q  <= {24'd0, req.corner_solid_bits};
			hits_q  <= '0;
		end
		if (state_q == ST_CROSS && cnt_q[0]) b_q[cnt_q[2:1]] <= acc_d[AXIS_W-1:0];
		if (state_q == ST_DOT && cnt_q == 3'd2) d_q <= acc_d;
		if (state_q == ST_CHECK && ax_q == AX_N && quad_hit) begin
			hits_q <= hits_q + 8'd1;
			case (hits_q)
				8'd0:    word_q[15:8]  <= idx_q + 8'd1;
				8'd1:    word_q[23:16] <= idx_q + 8'd1;
				8'd2:    word_q[31:24] <= idx_q + 8'd1;
				default: ;
			endcase
		end
		if (state_q == ST_DONE && out_free) begin
			out_word_q <= word_q;
			out_hits_q <= hits_q;
			out_many_q <= hits_q > 8'(MAX_SLOTS);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.voxel_word    = out_word_q;
	assign rsp.hit_count     = out_hits_q;
	assign rsp.too_many_hits = out_many_q;

	// the walk never runs past the quad count taken at query start
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (idx_q < count_q))
		else $error("quad index beyond count");

	// a quad walk starts with a table read
	a_cross_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CROSS && cnt_q == 3'd0) |-> $past(state_q) == ST_READ)
		else $error("cross product without table read");

	// overflow flag agrees with the hit count
	a_many_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.too_many_hits == (rsp.hit_count > 8'(MAX_SLOTS))))
		else $error("overflow flag mismatch");

	// no slot is filled without a hit
	a_empty_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.hit_count == 8'd0) |-> rsp.voxel_word[31:8] == 24'd0)
		else $error("slot filled without hit");
endmodule
`default_nettype wire

// File: tb/sv/tb_voxel_quad_collision_tagger.sv
// testbench of the voxel quad collision tagger: scoreboard class, stimulus tasks and top
`timescale 1ns / 1ps
`default_nettype none

import vqct_pkg::*;

// quad table mirror and queue of expected tag results
class tag_scoreboard;
	quad_entry_t quads[MAX_QUADS];
	logic [7:0] quad_count;
	logic [7:0] box_expand;
	logic [7:0] max_dist;
	logic [31:0] word_q[$];
	logic [7:0] count_q[$];
	logic flag_q[$];
	int errors;

	function new();
		quad_count = 8'd0;
		box_expand = 8'd51;
		max_dist = 8'd51;
		errors = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [7:0] v);
		if (idx == CFG_QUAD_COUNT) quad_count = v;
		else if (idx == CFG_BOX_EXPAND) box_expand = v;
		else if (idx == CFG_MAX_DIST) max_dist = v;
	endfunction

	function longint axis_comp(logic [23:0] p, int k);
		longint s;
		s = longint'(signed'(p[8*k +: 8]));
		if (s < -127) s = -127;
		return s;
	endfunction

	// min and max of the box projection onto an axis
	function void project(longint lo[3], longint hi[3], longint a[3],
			output longint mn, output longint mx);
		longint p, q;
		mn = 0;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			p = a[i] * lo[i];
			q = a[i] * hi[i];
			if (p < q) begin
				mn += p;
				mx += q;
			end else begin
				mn += q;
				mx += p;
			end
		end
	endfunction

	function bit quad_touches(quad_entry_t e, longint lo[3], longint hi[3]);
		longint sn[3], st[3], n[3], t[3], b[3], c3[3];
		longint mn, mx, c, len, d;
		c3[0] = e.cx;
		c3[1] = e.cy;
		c3[2] = e.cz;
		for (int k = 0; k < 3; k++) begin
			sn[k] = axis_comp(e.nrm, k);
			st[k] = axis_comp(e.tan, k);
			n[k] = sn[k] * 127;
			t[k] = st[k] * 127;
		end
		b[0] = sn[1] * st[2] - sn[2] * st[1];
		b[1] = sn[2] * st[0] - sn[0] * st[2];
		b[2] = sn[0] * st[1] - sn[1] * st[0];
		// tangent span
		project(lo, hi, t, mn, mx);
		c = c3[0] * t[0] + c3[1] * t[1] + c3[2] * t[2];
		len = longint'(e.tlen) * 16129;
		if (mx < c - len || mn > c + len) return 0;
		// bitangent span
		project(lo, hi, b, mn, mx);
		c = c3[0] * b[0] + c3[1] * b[1] + c3[2] * b[2];
		len = longint'(e.blen) * 16129;
		if (mx < c - len || mn > c + len) return 0;
		// distance to plane
		project(lo, hi, n, mn, mx);
		c = c3[0] * n[0] + c3[1] * n[1] + c3[2] * n[2];
		d = 0;
		if (c - mx > d) d = c - mx;
		if (mn - c > d) d = mn - c;
		return d < longint'(max_dist) * 16129;
	endfunction

	// note an accepted input transaction
	function void note_input(logic cmd, logic [7:0] idx, logic signed [19:0] px,
			logic signed [19:0] py, logic signed [19:0] pz, logic [23:0] nrm,
			logic [23:0] tan, logic [15:0] tl, logic [15:0] bl, logic [7:0] solid);
		longint lo[3], hi[3], o[3];
		logic [31:0] word;
		int hits;
		if (cmd == CMD_LOAD) begin
			if (idx < MAX_QUADS) quads[idx] = '{px, py, pz, nrm, tan, tl, bl};
			return;
		end
		o[0] = px;
		o[1] = py;
		o[2] = pz;
		for (int i = 0; i < 3; i++) begin
			lo[i] = o[i] - longint'(box_expand);
			hi[i] = o[i] + 256 + longint'(box_expand);
		end
		word = {24'd0, solid};
		hits = 0;
		for (int i = 0; i < quad_count && i < MAX_QUADS; i++)
			if (quad_touches(quads[i], lo, hi)) begin
				if (hits < MAX_SLOTS) word[8 + 8*hits +: 8] = 8'(i + 1);
				hits++;
			end
		word_q.push_back(word);
		count_q.push_back(8'(hits));
		flag_q.push_back(hits > MAX_SLOTS);
	endfunction

	// compare one result transaction with the oldest expectation
	function void check_result(logic [31:0] w, logic [7:0] hc, logic f);
		if (word_q.size() == 0) begin
			$display("%0t: unexpected result word %h count %0d", $time, w, hc);
			errors++;
			return;
		end
		if (w !== word_q[0]) begin
			$display("%0t: voxel_word expected %h actual %h", $time, word_q[0], w);
			errors++;
		end
		if (hc !== count_q[0]) begin
			$display("%0t: hit_count expected %0d actual %0d", $time, count_q[0], hc);
			errors++;
		end
		if (f !== flag_q[0]) begin
			$display("%0t: too_many_hits expected %b actual %b", $time, flag_q[0], f);
			errors++;
		end
		void'(word_q.pop_front());
		void'(count_q.pop_front());
		void'(flag_q.pop_front());
	endfunction
endclass

module tb_voxel_quad_collision_tagger;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;
	bit calm = 0;
	longint cycles = 0;
	int loaded = 0;

	vqct_req_if req();
	vqct_rsp_if rsp();

	voxel_quad_collision_tagger DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req.sink),
		.rsp(rsp.source)
	);

	tag_scoreboard sb = new();

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0;
		req.cmd = CMD_LOAD;
		req.quad_index = '0;
		req.pos_x = '0;
		req.pos_y = '0;
		req.pos_z = '0;
		req.normal_packed = '0;
		req.tangent_packed = '0;
		req.tangent_half_len = '0;
		req.bitangent_half_len = '0;
		req.corner_solid_bits = '0;
		rsp.ready = 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 4000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: sample on rising edge, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.voxel_word, rsp.hit_count, rsp.too_many_hits);
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 5);
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	task automatic write_cfg(logic [1:0] idx, logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, v);
	endtask

	// send one transaction, with an optional random gap before it
	task automatic send(logic cmd, logic [7:0] idx, logic signed [19:0] px,
			logic signed [19:0] py, logic signed [19:0] pz, logic [23:0] nrm,
			logic [23:0] tan, logic [15:0] tl, logic [15:0] bl, logic [7:0] solid);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.quad_index <= idx;
		req.pos_x <= px;
		req.pos_y <= py;
		req.pos_z <= pz;
		req.normal_packed <= nrm;
		req.tangent_packed <= tan;
		req.tangent_half_len <= tl;
		req.bitangent_half_len <= bl;
		req.corner_solid_bits <= solid;
		do @(posedge clk); while (!req.ready);
		sb.note_input(cmd, idx, px, py, pz, nrm, tan, tl, bl, solid);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.word_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_axis_byte();
		case ($urandom_range(0, 5))
			0: return 8'h80;
			1: return 8'h7f;
			2: return 8'h81;
			3: return 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] rand_axis();
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 2))
				0: return {8'h00, 8'h00, 8'(($urandom_range(0, 1)) ? 8'h7f : 8'h81)};
				1: return {8'h00, 8'(($urandom_range(0, 1)) ? 8'h7f : 8'h81), 8'h00};
				default: return {8'(($urandom_range(0, 1)) ? 8'h7f : 8'h81), 16'h0};
			endcase
		end
		return {rand_axis_byte(), rand_axis_byte(), rand_axis_byte()};
	endfunction

	// positions mostly near the origin so hits happen, sometimes full range
	function automatic logic signed [19:0] rand_pos();
		if ($urandom_range(0, 9) == 0) return 20'($urandom);
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(0, 1) ? 20'sh7ffff : 20'sh80000;
		return 20'($signed($urandom_range(0, 2047)) - 1024);
	endfunction

	task automatic rand_load(int top);
		logic [7:0] idx;
		idx = 8'($urandom_range(0, top));
		if ($urandom_range(0, 40) == 0) idx = 8'd255;
		send(CMD_LOAD, idx, rand_pos(), rand_pos(), rand_pos(), rand_axis(), rand_axis(),
			$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1023)),
			$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1023)),
			8'($urandom));
	endtask

	task automatic rand_query();
		send(CMD_QUERY, 8'($urandom), rand_pos(), rand_pos(), rand_pos(), 24'($urandom),
			24'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// fill table slots 0..top so that queries read only written entries
	task automatic fill(int top);
		for (int i = 0; i <= top; i++)
			send(CMD_LOAD, 8'(i), rand_pos(), rand_pos(), rand_pos(), rand_axis(),
				rand_axis(), 16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
				8'($urandom));
		req.valid <= 1'b0;
		if (top + 1 > loaded) loaded = top + 1;
	endtask

	task automatic phase(int n_items, int count, logic [7:0] be, logic [7:0] md);
		write_cfg(CFG_BOX_EXPAND, be);
		write_cfg(CFG_MAX_DIST, md);
		write_cfg(CFG_QUAD_COUNT, 8'(count));
		for (int i = 0; i < n_items; i++)
			if ($urandom_range(0, 2) == 0) rand_load(count > 0 ? count - 1 : 0);
			else rand_query();
		drain();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: query with an empty table, default registers
		send(CMD_QUERY, 8'hff, 20'sh7ffff, 20'sh80000, 20'sh0, 24'hffffff, 24'hffffff,
			16'hffff, 16'hffff, 8'hff);
		send(CMD_QUERY, 8'h00, 20'sh0, 20'sh0, 20'sh0, 24'h0, 24'h0, 16'h0, 16'h0, 8'h00);
		// out of range load is ignored
		send(CMD_LOAD, 8'd255, 20'sh7ffff, 20'sh80000, 20'sh7ffff, 24'h808080, 24'h7f7f7f,
			16'hffff, 16'hffff, 8'hff);
		// five quads on the plane z=0 around the origin: more than three hits
		for (int i = 0; i < 5; i++)
			send(CMD_LOAD, 8'(i), 20'sh80, 20'sh80, 20'sh0, 24'h7f0000,
				i == 4 ? 24'h000080 : 24'h00007f, 16'h0100, 16'h0100, 8'h00);
		// a quad far away with a clamped -128 normal
		send(CMD_LOAD, 8'd5, 20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 24'h800000, 24'h000081,
			16'h0, 16'h0, 8'h0);
		loaded = 6;
		drain();
		write_cfg(CFG_QUAD_COUNT, 8'd6);
		write_cfg(CFG_UNUSED, 8'hff);
		send(CMD_QUERY, 8'h0, 20'sh0, 20'sh0, 20'sh0, 24'h0, 24'h0, 16'h0, 16'h0, 8'ha5);
		send(CMD_QUERY, 8'h0, 20'sh0, 20'sh0, -20'sh100, 24'h0, 24'h0, 16'h0, 16'h0, 8'h5a);
		send(CMD_QUERY, 8'h0, 20'sh7ff00, 20'sh7ff00, 20'sh7ff00, 24'h0, 24'h0, 16'h0,
			16'h0, 8'h01);
		// sender holds off until every expected result has come
		drain();
		write_cfg(CFG_BOX_EXPAND, 8'd0);
		write_cfg(CFG_MAX_DIST, 8'd0);
		send(CMD_QUERY, 8'h0, 20'sh0, 20'sh0, 20'sh0, 24'h0, 24'h0, 16'h0, 16'h0, 8'hff);
		drain();
		write_cfg(CFG_BOX_EXPAND, 8'd255);
		write_cfg(CFG_MAX_DIST, 8'd255);
		send(CMD_QUERY, 8'h0, 20'sh0, 20'sh0, 20'sh0, 24'h0, 24'h0, 16'h0, 16'h0, 8'h3c);
		drain();

		// random phases, small tables mostly
		fill(7);
		phase(150, 8, 8'd51, 8'd51);
		phase(250, 4, 8'd255, 8'd255);
		phase(100, 8, 8'd0, 8'd0);
		phase(120, 0, 8'($urandom), 8'($urandom));
		fill(254);
		phase(25, 255, 8'd128, 8'd200);
		fill(15);
		calm = 1;
		phase(210, 16, 8'($urandom), 8'($urandom));

		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
